// ===== hw/rtl/fbsc_pkg.sv =====
// Shared types and constants for the frustum cull pipeline.
// No dependencies; used by fbsc_cfg_regs, fbsc_plane_eval and frustum_box_sphere_cull.
package fbsc_pkg;

    localparam int PLANE_COUNT = 6;
    localparam int AXIS_COUNT  = 3;
    localparam int NORM_W      = 16;
    localparam int NORM_FRAC   = 14;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int OUT_TDATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LEFT   = 3'd0,
        CFG_RIGHT  = 3'd1,
        CFG_BOTTOM = 3'd2,
        CFG_TOP    = 3'd3,
        CFG_NEAR   = 3'd4,
        CFG_FAR    = 3'd5
    } t_cfg_idx;

    // Plane register layout, lowest bits first: nx Q1.14, ny, nz, d Q15.0.
    typedef struct packed {
        logic signed [NORM_W-1:0] d;
        logic signed [NORM_W-1:0] nz;
        logic signed [NORM_W-1:0] ny;
        logic signed [NORM_W-1:0] nx;
    } t_plane;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } t_stage_en;

endpackage

// ===== hw/rtl/fbsc_cfg_regs.sv =====
// Plane register file: six 64-bit planes written through the config port.
// Depends on fbsc_pkg.
module fbsc_cfg_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [fbsc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [fbsc_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    output fbsc_pkg::t_plane                  o_plane [fbsc_pkg::PLANE_COUNT]
);

    fbsc_pkg::t_plane r_plane [fbsc_pkg::PLANE_COUNT];
    fbsc_pkg::t_plane n_plane [fbsc_pkg::PLANE_COUNT];

    always_comb begin
        n_plane = r_plane;
        if (i_cfg_we) begin
            unique case (fbsc_pkg::t_cfg_idx'(i_cfg_idx))
                fbsc_pkg::CFG_LEFT:   n_plane[fbsc_pkg::CFG_LEFT]   = i_cfg_wdata;
                fbsc_pkg::CFG_RIGHT:  n_plane[fbsc_pkg::CFG_RIGHT]  = i_cfg_wdata;
                fbsc_pkg::CFG_BOTTOM: n_plane[fbsc_pkg::CFG_BOTTOM] = i_cfg_wdata;
                fbsc_pkg::CFG_TOP:    n_plane[fbsc_pkg::CFG_TOP]    = i_cfg_wdata;
                fbsc_pkg::CFG_NEAR:   n_plane[fbsc_pkg::CFG_NEAR]   = i_cfg_wdata;
                fbsc_pkg::CFG_FAR:    n_plane[fbsc_pkg::CFG_FAR]    = i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < fbsc_pkg::PLANE_COUNT; p++) begin
                r_plane[p] <= '0;
            end
        end else begin
            r_plane <= n_plane;
        end
    end

    assign o_plane = r_plane;

endmodule

// ===== hw/rtl/fbsc_plane_eval.sv =====
// One plane of the cull test: products, per-axis worst corner, distance sign.
// Three register stages driven by stage enables; depends on fbsc_pkg.
module fbsc_plane_eval #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                           i_clk,
    input  fbsc_pkg::t_stage_en            i_en,
    input  fbsc_pkg::t_plane               i_plane,
    input  logic signed [COORD_WIDTH-1:0]  i_lo [fbsc_pkg::AXIS_COUNT],
    input  logic signed [COORD_WIDTH-1:0]  i_hi [fbsc_pkg::AXIS_COUNT],
    input  logic                           i_kind1,
    input  logic [COORD_WIDTH-2:0]         i_rad2,
    output logic                           o_cull
);

    localparam int PROD_W = COORD_WIDTH + fbsc_pkg::NORM_W;
    localparam int SUM_W  = (COORD_WIDTH + 19 > 32) ? COORD_WIDTH + 19 : 32;

    logic signed [fbsc_pkg::NORM_W-1:0] w_norm [fbsc_pkg::AXIS_COUNT];
    logic signed [PROD_W-1:0]           r_plo  [fbsc_pkg::AXIS_COUNT];
    logic signed [PROD_W-1:0]           r_phi  [fbsc_pkg::AXIS_COUNT];
    logic signed [PROD_W-1:0]           r_term [fbsc_pkg::AXIS_COUNT];
    logic signed [SUM_W-1:0]            w_dterm;
    logic signed [SUM_W-1:0]            w_rterm;
    logic signed [SUM_W-1:0]            w_sum;
    logic                               r_cull;

    assign w_norm[0] = i_plane.nx;
    assign w_norm[1] = i_plane.ny;
    assign w_norm[2] = i_plane.nz;

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            for (int a = 0; a < fbsc_pkg::AXIS_COUNT; a++) begin
                r_plo[a] <= PROD_W'(w_norm[a]) * PROD_W'(i_lo[a]);
                r_phi[a] <= PROD_W'(w_norm[a]) * PROD_W'(i_hi[a]);
            end
        end
    end

    // Box: take the corner farthest along the normal per axis. Sphere: centre only.
    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            for (int a = 0; a < fbsc_pkg::AXIS_COUNT; a++) begin
                if (i_kind1 || (r_plo[a] > r_phi[a])) begin
                    r_term[a] <= r_plo[a];
                end else begin
                    r_term[a] <= r_phi[a];
                end
            end
        end
    end

    assign w_dterm = SUM_W'(i_plane.d) <<< fbsc_pkg::NORM_FRAC;
    assign w_rterm = $signed(SUM_W'({i_rad2, {fbsc_pkg::NORM_FRAC{1'b0}}}));
    assign w_sum   = SUM_W'(r_term[0]) + SUM_W'(r_term[1]) + SUM_W'(r_term[2])
                   + w_dterm + w_rterm;

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_cull <= w_sum[SUM_W-1];
        end
    end

    assign o_cull = r_cull;

endmodule

// ===== hw/rtl/frustum_box_sphere_cull.sv =====
// Frustum cull of one box or sphere per transfer against six config planes.
// Top level; depends on fbsc_pkg, fbsc_cfg_regs and fbsc_plane_eval.
//
// One object is accepted per clock while the output side does not stall, and its
// visible flag is presented through five register stages: input register,
// normal-by-coordinate multiply, worst-corner select, distance sum and sign, then the
// six-way reduce into the output register.
// The multiply stage sets the cycle time (36 products of 16 by COORD_WIDTH
// bits in parallel). Stalls on the output side fill bubbles first, so the
// input keeps accepting until all five stages hold an item. Plane registers
// take effect for items accepted after the write; write them only while the
// pipeline is empty. A box is culled when all eight corners lie strictly
// behind one plane; a sphere when its centre lies strictly below -radius.
module frustum_box_sphere_cull #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z, radius, zero pad
    input  logic [((7*COORD_WIDTH-1+7)/8)*8-1:0] i_s_tdata,
    // kind: 0 box, 1 sphere
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // visible, zero pad
    output logic [fbsc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                                i_cfg_we,
    input  logic [fbsc_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fbsc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int STAGES = 5;
    localparam int RAD_LO = 6 * COORD_WIDTH;

    fbsc_pkg::t_plane    w_plane [fbsc_pkg::PLANE_COUNT];
    fbsc_pkg::t_stage_en w_en;
    logic [STAGES-1:0]   w_rdy;
    logic [STAGES-1:0]   r_vld;

    logic signed [COORD_WIDTH-1:0] r_lo0 [fbsc_pkg::AXIS_COUNT];
    logic signed [COORD_WIDTH-1:0] r_hi0 [fbsc_pkg::AXIS_COUNT];
    logic                          r_kind0;
    logic [COORD_WIDTH-2:0]        r_rad0;
    logic                          r_kind1;
    logic [COORD_WIDTH-2:0]        r_rad1;
    logic [COORD_WIDTH-2:0]        r_rad2;
    logic [fbsc_pkg::PLANE_COUNT-1:0] w_cull;
    logic                          r_vis;

    // Advance a stage when it is empty or its successor advances.
    always_comb begin
        w_rdy[STAGES-1] = !r_vld[STAGES-1] || i_m_tready;
        for (int k = STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    assign w_en.s1   = w_rdy[1];
    assign w_en.s2   = w_rdy[2];
    assign w_en.s3   = w_rdy[3];
    assign o_s_tready = w_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_vld[0] <= i_s_tvalid;
            end
            for (int k = 1; k < STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            for (int a = 0; a < fbsc_pkg::AXIS_COUNT; a++) begin
                r_lo0[a] <= i_s_tdata[a*COORD_WIDTH +: COORD_WIDTH];
                r_hi0[a] <= i_s_tdata[(a+3)*COORD_WIDTH +: COORD_WIDTH];
            end
            r_kind0 <= i_s_tuser;
            r_rad0  <= i_s_tdata[RAD_LO +: COORD_WIDTH-1];
        end
        if (w_rdy[1]) begin
            r_kind1 <= r_kind0;
            r_rad1  <= r_kind0 ? r_rad0 : '0;
        end
        if (w_rdy[2]) begin
            r_rad2 <= r_rad1;
        end
        if (w_rdy[4]) begin
            r_vis <= ~|w_cull;
        end
    end

    fbsc_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_plane     (w_plane)
    );

    for (genvar p = 0; p < fbsc_pkg::PLANE_COUNT; p++) begin : g_plane
        fbsc_plane_eval #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_eval (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_plane (w_plane[p]),
            .i_lo    (r_lo0),
            .i_hi    (r_hi0),
            .i_kind1 (r_kind1),
            .i_rad2  (r_rad2),
            .o_cull  (w_cull[p])
        );
    end

    assign o_m_tvalid = r_vld[STAGES-1];
    assign o_m_tdata  = {{(fbsc_pkg::OUT_TDATA_W-1){1'b0}}, r_vis};

    a_full_when_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (&r_vld))
        else $error("input blocked with an empty stage");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> r_vld[0])
        else $error("accepted transfer missing from first stage");

    a_reduce_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[3] && w_rdy[4]) |=> r_vld[4])
        else $error("item lost between distance and output stage");

    a_box_no_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[1] && !r_kind1) |-> (r_rad1 == '0))
        else $error("radius leaked into a box test");

endmodule

// ===== tb/tb_frustum_box_sphere_cull.sv =====
// Self-checking testbench for frustum_box_sphere_cull: box and sphere culls against six planes.
// Holds its own culling predictor in a scoreboard class; depends on fbsc_pkg and the RTL top.
`timescale 1ns / 100ps

module tb_frustum_box_sphere_cull;
    import fbsc_pkg::*;

    localparam int COORD_W      = 16;
    localparam int RADIUS_W     = COORD_W - 1;
    localparam int TDATA_W      = ((7 * COORD_W - 1 + 7) / 8) * 8;
    localparam int CORNER_COUNT = 8;
    localparam int VISIBLE_BIT  = 0;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 200;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;

    typedef enum bit {
        KIND_BOX    = 1'b0,
        KIND_SPHERE = 1'b1
    } obj_kind_e;

    typedef enum int {
        PL_FRUSTUM,
        PL_RANDOM,
        PL_MIXED_EXTREME,
        PL_MOST_NEG,
        PL_MOST_POS,
        PL_ONES,
        PL_ZERO
    } plane_style_e;

    typedef struct {
        obj_kind_e           kind;
        logic [COORD_W-1:0]  first [3];
        logic [COORD_W-1:0]  second [3];
        logic [RADIUS_W-1:0] radius;
    } cull_obj_t;

    class cull_scoreboard;
        t_plane planes [PLANE_COUNT];
        bit     visible_q [$];
        int     errors;
        int     n_box;
        int     n_sphere;
        int     n_culled;

        function new();
            foreach (planes[i]) planes[i] = '0;
        endfunction

        function void set_plane(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            if (idx < PLANE_COUNT) planes[idx] = val;
        endfunction

        function longint plane_dist(t_plane pl, logic [COORD_W-1:0] x,
                                    logic [COORD_W-1:0] y, logic [COORD_W-1:0] z);
            return longint'($signed(pl.nx)) * longint'($signed(x))
                 + longint'($signed(pl.ny)) * longint'($signed(y))
                 + longint'($signed(pl.nz)) * longint'($signed(z))
                 + (longint'($signed(pl.d)) <<< NORM_FRAC);
        endfunction

        function bit predict_visible(cull_obj_t o);
            longint dist_val;
            int     below;
            for (int p = 0; p < PLANE_COUNT; p++) begin
                if (o.kind == KIND_SPHERE) begin
                    dist_val = plane_dist(planes[p], o.first[0], o.first[1], o.first[2]);
                    if (dist_val < -(longint'(o.radius) <<< NORM_FRAC)) return 1'b0;
                end else begin
                    below = 0;
                    for (int c = 0; c < CORNER_COUNT; c++) begin
                        dist_val = plane_dist(planes[p],
                                              c[0] ? o.second[0] : o.first[0],
                                              c[1] ? o.second[1] : o.first[1],
                                              c[2] ? o.second[2] : o.first[2]);
                        if (dist_val < 0) below++;
                    end
                    if (below == CORNER_COUNT) return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_input(cull_obj_t o);
            bit vis;
            vis = predict_visible(o);
            visible_q.push_back(vis);
            if (o.kind == KIND_SPHERE) n_sphere++;
            else n_box++;
            if (!vis) n_culled++;
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 50) $display("MISMATCH at %0t: %s", $time, msg);
        endtask

        task check_result(logic got);
            bit want;
            if (visible_q.size() == 0) begin
                report("result transfer with no object pending");
            end else begin
                want = visible_q.pop_front();
                if (got !== want)
                    report($sformatf("visible got %b want %b", got, want));
            end
        endtask
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [TDATA_W-1:0]    i_s_tdata = '0;
    logic                  i_s_tuser = 1'b0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    cull_scoreboard sb;
    int tx_max = 0;
    int rx_max = 0;
    int n_settings = 0;

    frustum_box_sphere_cull #(
        .COORD_WIDTH(COORD_W)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("FAIL frustum_box_sphere_cull");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata[VISIBLE_BIT]);
    end

    initial begin
        int unsigned hold;
        repeat (10) @(posedge i_clk);
        forever begin
            hold = (rx_max > 0) ? $urandom_range(0, rx_max) : 0;
            if (hold != 0) begin
                i_m_tready <= 1'b0;
                repeat (hold) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            @(posedge i_clk);
            while (!(o_m_tvalid && i_m_tready)) @(posedge i_clk);
        end
    end

    function automatic logic [CFG_DATA_W-1:0] pack_plane(logic [15:0] nx, logic [15:0] ny,
                                                         logic [15:0] nz, logic [15:0] d);
        return {d, nz, ny, nx};
    endfunction

    function automatic logic [15:0] pick_extreme();
        case ($urandom_range(0, 6))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            4: return 16'h4000;
            5: return 16'hC000;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] make_plane(plane_style_e style, int p);
        int n [3];
        int d;
        case (style)
            PL_MOST_NEG: return 64'h8000_8000_8000_8000;
            PL_MOST_POS: return 64'h7FFF_7FFF_7FFF_7FFF;
            PL_ONES:     return '1;
            PL_ZERO:     return '0;
            PL_RANDOM:   return {$urandom, $urandom};
            PL_MIXED_EXTREME:
                return pack_plane(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme());
            default: begin
                // axis-aligned slab face with a tilt, facing inward
                foreach (n[i]) n[i] = int'($urandom_range(0, 2048)) - 1024;
                n[p / 2] = ((p % 2 == 0) ? 16384 : -16384) + int'($urandom_range(0, 1024)) - 512;
                d = $urandom_range(256, 4096);
                return pack_plane(16'(n[0]), 16'(n[1]), 16'(n[2]), 16'(d));
            end
        endcase
    endfunction

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        sb.set_plane(idx, val);
        @(posedge i_clk);
    endtask

    task automatic cfg_done();
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        n_settings++;
    endtask

    task automatic setup_planes(plane_style_e style);
        for (int i = CFG_LEFT; i <= CFG_FAR; i++) cfg_write(CFG_IDX_W'(i), make_plane(style, i));
        cfg_write(CFG_UNUSED_A, {$urandom, $urandom});
        cfg_write(CFG_UNUSED_B, {$urandom, $urandom});
        cfg_done();
    endtask

    task automatic send_obj(cull_obj_t o);
        int unsigned gap;
        gap = (tx_max > 0) ? $urandom_range(0, tx_max) : 0;
        if (gap != 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= o.kind;
        i_s_tdata  <= {1'b0, o.radius, o.second[2], o.second[1], o.second[0],
                       o.first[2], o.first[1], o.first[0]};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_input(o);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.visible_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic cull_obj_t mk_obj(obj_kind_e kind, int fx, int fy, int fz,
                                         int sx, int sy, int sz, int r);
        cull_obj_t o;
        o.kind      = kind;
        o.first[0]  = COORD_W'(fx);
        o.first[1]  = COORD_W'(fy);
        o.first[2]  = COORD_W'(fz);
        o.second[0] = COORD_W'(sx);
        o.second[1] = COORD_W'(sy);
        o.second[2] = COORD_W'(sz);
        o.radius    = RADIUS_W'(r);
        return o;
    endfunction

    function automatic logic [COORD_W-1:0] rand_coord();
        if ($urandom_range(0, 3) == 0) return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 8191)) - 4096);
    endfunction

    function automatic cull_obj_t rand_obj();
        cull_obj_t o;
        o.kind = $urandom_range(0, 1) ? KIND_SPHERE : KIND_BOX;
        for (int i = 0; i < 3; i++) begin
            o.first[i] = rand_coord();
            case ($urandom_range(0, 7))
                0: o.second[i] = COORD_W'($urandom);
                1: o.second[i] = o.first[i] - COORD_W'($urandom_range(1, 2048));
                default: o.second[i] = o.first[i] + COORD_W'($urandom_range(0, 2048));
            endcase
        end
        o.radius = ($urandom_range(0, 7) == 0) ? RADIUS_W'($urandom)
                                                : RADIUS_W'($urandom_range(0, 2048));
        return o;
    endfunction

    initial begin
        plane_style_e phase_style [PHASE_COUNT];
        int phase_tx [PHASE_COUNT];
        int phase_rx [PHASE_COUNT];

        phase_style = '{PL_FRUSTUM, PL_FRUSTUM, PL_RANDOM,
            PL_MIXED_EXTREME, PL_ONES, PL_ZERO, PL_FRUSTUM, PL_RANDOM, PL_MIXED_EXTREME,
            PL_FRUSTUM};
        phase_tx = '{0, 14, 14, 14, 14, 0, 0, 14, 0, 14};
        phase_rx = '{0, 14, 14, 14, 0, 14, 0, 14, 0, 14};

        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        tx_max = 3;
        rx_max = 3;

        // planes still zero after reset: nothing may be culled
        send_obj(mk_obj(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_obj(mk_obj(KIND_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 32767));
        send_obj(mk_obj(KIND_SPHERE, -32768, -32768, -32768, 32767, 0, -1, 0));
        send_obj(mk_obj(KIND_SPHERE, 32767, 32767, 32767, -32768, 5, 9, 32767));
        drain();

        // single plane x >= 0; writes to unused indexes must not land anywhere
        cfg_write(CFG_LEFT, pack_plane(16'h4000, 16'h0000, 16'h0000, 16'h0000));
        cfg_write(CFG_UNUSED_A, '1);
        cfg_write(CFG_UNUSED_B, 64'h8000_8000_8000_8000);
        cfg_done();
        send_obj(mk_obj(KIND_BOX, 0, -300, 7, 100, 300, 90, 0));
        send_obj(mk_obj(KIND_BOX, -1280, 0, 0, -1, 10, 10, 0));
        send_obj(mk_obj(KIND_BOX, -1, 5, 5, -1280, -5, -5, 0));
        send_obj(mk_obj(KIND_BOX, 1280, 5, 5, -1280, -5, -5, 0));
        send_obj(mk_obj(KIND_BOX, -1, 0, 0, 0, 0, 0, 0));
        send_obj(mk_obj(KIND_SPHERE, -256, 11, -11, 32767, -32768, 1, 256));
        send_obj(mk_obj(KIND_SPHERE, -257, 0, 0, 0, 0, 0, 256));
        send_obj(mk_obj(KIND_SPHERE, -32768, 0, 0, 0, 0, 0, 32767));
        send_obj(mk_obj(KIND_SPHERE, -32767, 0, 0, 0, 0, 0, 32767));
        send_obj(mk_obj(KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0));
        send_obj(mk_obj(KIND_SPHERE, -1, 0, 0, 0, 0, 0, 0));
        drain();

        setup_planes(PL_MOST_NEG);
        send_obj(mk_obj(KIND_BOX, -32768, -32768, -32768, -32768, -32768, -32768, 0));
        send_obj(mk_obj(KIND_BOX, 32767, 32767, 32767, 32767, 32767, 32767, 0));
        send_obj(mk_obj(KIND_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767));
        send_obj(mk_obj(KIND_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0));
        drain();

        setup_planes(PL_MOST_POS);
        send_obj(mk_obj(KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_obj(mk_obj(KIND_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767));
        drain();

        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            setup_planes(phase_style[ph]);
            tx_max = phase_tx[ph];
            rx_max = phase_rx[ph];
            repeat (PHASE_ITEMS) send_obj(rand_obj());
            drain();
        end

        repeat (20) @(posedge i_clk);
        $display("Checked %0d objects (%0d boxes, %0d spheres), %0d culled, over %0d plane sets.",
                 sb.n_box + sb.n_sphere, sb.n_box, sb.n_sphere, sb.n_culled, n_settings);
        if (sb.errors == 0) begin
            $display("PASS frustum_box_sphere_cull");
        end else begin
            $display("%0d mismatches", sb.errors);
            $display("FAIL frustum_box_sphere_cull");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/fbsc_pkg.sv
hw/rtl/fbsc_cfg_regs.sv
hw/rtl/fbsc_plane_eval.sv
hw/rtl/frustum_box_sphere_cull.sv
tb/tb_frustum_box_sphere_cull.sv
